// File: src/pic_pkg.sv
// Shared types and constants of the platform interrupt controller.
`default_nettype none
package pic_pkg;

  localparam int NUM_SOURCES_DEF  = 96;
  localparam int NUM_CONTEXTS_DEF = 2;
  localparam int PRIO_BITS_DEF    = 3;

  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_REQ   = 2'd2;

  localparam logic [25:0] PEND_BASE   = 26'h0001000;
  localparam logic [25:0] ENABLE_BASE = 26'h0002000;
  localparam logic [25:0] CTX_BASE    = 26'h0200000;
  localparam logic [11:0] REG_THRESH  = 12'h000;
  localparam logic [11:0] REG_CLAIM   = 12'h004;

  typedef struct packed {
    logic [1:0]  mode;
    logic [25:0] address;
    logic [31:0] write_data;
    logic [6:0]  source_id;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  irq_lines;
  } out_item_t;

endpackage
`default_nettype wire

// File: src/pic_prio_mem.sv
// Source priority memory with per-entry valid bits and registered read data.
`default_nettype none
module pic_prio_mem #(
  parameter int DEPTH = 96,
  parameter int WIDTH = 3,
  parameter int AW    = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// File: src/platform_interrupt_controller_unit.sv
// Top level of the platform interrupt controller: decode, gateway and claim scan.
// Sequence: an accepted access scans the sources (S_SCAN, S_FLUSH, S_END) before S_OUT
// presents its result; a priority read passes S_PRD first, and a claim read scans twice.
// Throughput: one request at a time; the scan reads the priority memory one source
// per cycle through its single read port.
// Reset: synchronous active-low rst_n clears priorities, pending, in-service,
// enables and thresholds at once (priority entries through valid bits).
`default_nettype none
module platform_interrupt_controller_unit #(
  parameter int NUM_SOURCES  = pic_pkg::NUM_SOURCES_DEF,
  parameter int NUM_CONTEXTS = pic_pkg::NUM_CONTEXTS_DEF,
  parameter int PRIO_BITS    = pic_pkg::PRIO_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pic_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output pic_pkg::out_item_t     out_data
);
  import pic_pkg::*;

  localparam int EN_WORDS = (NUM_SOURCES + 31) / 32;
  localparam int EN_BITS  = EN_WORDS * 32;
  localparam int ID_W     = $clog2(NUM_SOURCES);
  localparam int SC_W     = $clog2(NUM_SOURCES + 1);
  localparam int WORD_W   = (EN_WORDS > 1) ? $clog2(EN_WORDS) : 1;
  localparam int CTX_W    = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRD   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_END   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // Control state.
  logic [2:0]                  state_r;
  logic [SC_W-1:0]             scan_id_r;
  logic                        rd_v_r;
  logic                        claim_r;
  logic                        out_valid_r;
  logic [EN_BITS-1:0]          pend_r;
  logic [NUM_SOURCES-1:0]      insvc_r;
  logic [EN_BITS-1:0]          en_r [NUM_CONTEXTS];
  logic [PRIO_BITS-1:0]        thr_r [NUM_CONTEXTS];
  logic [PRIO_BITS-1:0]        best_p_r [NUM_CONTEXTS];

  // Payload state.
  logic [ID_W-1:0]             rd_id_r;
  logic [ID_W-1:0]             best_id_r [NUM_CONTEXTS];
  logic [CTX_W-1:0]            claim_ctx_r;
  logic                        prio_ok_r;
  logic [31:0]                 rd_r;
  out_item_t                   out_r;

  logic                        acc;
  logic [25:0]                 addr;
  logic                        is_prio, is_pend, is_en, is_ctx;
  logic [9:0]                  prio_id;
  logic                        prio_ok, pend_ok, en_ok, cx_ok;
  logic [25:0]                 en_off, cx_off;
  logic [18:0]                 en_ctx;
  logic [4:0]                  en_w;
  logic [13:0]                 cx_ctx;
  logic [11:0]                 cx_reg;
  logic [CTX_W-1:0]            en_ci, cx_ci;
  logic [WORD_W-1:0]           en_wi, pend_wi;
  logic [31:0]                 wmask;
  logic [31:0]                 rd_val;
  logic                        src_ok;
  logic [ID_W-1:0]             src_i;
  logic                        cmp_ok;
  logic [ID_W-1:0]             cmp_i;
  logic                        mem_we, mem_re;
  logic [ID_W-1:0]             mem_waddr, mem_raddr;
  logic [PRIO_BITS-1:0]        mem_rdata;
  logic [1:0]                  lines;
  logic [ID_W-1:0]             claim_id;
  logic                        out_free;

  assign acc      = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Address decode of the request at the input.
  always_comb begin
    addr    = {in_data.address[25:2], 2'b00};
    is_prio = addr < PEND_BASE;
    is_pend = !is_prio && (addr < ENABLE_BASE);
    is_en   = (addr >= ENABLE_BASE) && (addr < CTX_BASE);
    is_ctx  = addr >= CTX_BASE;
    prio_id = addr[11:2];
    prio_ok = (prio_id != 10'd0) && (prio_id < NUM_SOURCES);
    pend_ok = addr[11:2] < EN_WORDS;
    pend_wi = WORD_W'(addr[11:2]);
    en_off  = addr - ENABLE_BASE;
    en_ctx  = en_off[25:7];
    en_w    = en_off[6:2];
    en_ok   = (en_ctx < NUM_CONTEXTS) && (en_w < EN_WORDS);
    en_ci   = CTX_W'(en_ctx);
    en_wi   = WORD_W'(en_w);
    cx_off  = addr - CTX_BASE;
    cx_ctx  = cx_off[25:12];
    cx_reg  = cx_off[11:0];
    cx_ok   = cx_ctx < NUM_CONTEXTS;
    cx_ci   = CTX_W'(cx_ctx);
    src_ok  = (in_data.source_id != 7'd0) && (in_data.source_id < NUM_SOURCES);
    src_i   = ID_W'(in_data.source_id);
    cmp_i   = ID_W'(in_data.write_data);
    cmp_ok  = (in_data.write_data != 32'd0) && (in_data.write_data < NUM_SOURCES) &&
              en_r[cx_ci][cmp_i];
    // Enable bits that name real, non-zero sources of the addressed word.
    for (int b = 0; b < 32; b++) begin
      wmask[b] = ((32 * int'(en_w) + b) != 0) && ((32 * int'(en_w) + b) < NUM_SOURCES);
    end
  end

  // Read data for accesses that do not need the priority memory or the scan.
  always_comb begin
    rd_val = '0;
    if (is_pend && pend_ok) begin
      rd_val = pend_r[pend_wi*32 +: 32];
    end else if (is_en && en_ok) begin
      rd_val = en_r[en_ci][en_wi*32 +: 32];
    end else if (is_ctx && cx_ok && cx_reg == REG_THRESH) begin
      rd_val = 32'(thr_r[cx_ci]);
    end
  end

  // Priority memory: written by bus writes, read by priority reads and the scan.
  assign mem_we    = acc && (in_data.mode == MODE_WRITE) && is_prio && prio_ok;
  assign mem_waddr = ID_W'(prio_id);
  assign mem_re    = (acc && (in_data.mode == MODE_READ) && is_prio) || (state_r == S_SCAN);
  assign mem_raddr = (state_r == S_SCAN) ? ID_W'(scan_id_r) : ID_W'(prio_id);

  pic_prio_mem #(
    .DEPTH (NUM_SOURCES),
    .WIDTH (PRIO_BITS),
    .AW    (ID_W)
  ) u_prio_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_data.write_data[PRIO_BITS-1:0]),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign claim_id = best_id_r[claim_ctx_r];

  // One interrupt line per context; contexts beyond the port width are not shown.
  for (genvar i = 0; i < 2; i++) begin : g_lines
    if (i < NUM_CONTEXTS) begin : g_on
      assign lines[i] = (best_p_r[i] != '0);
    end else begin : g_off
      assign lines[i] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_id_r   <= '0;
      rd_v_r      <= 1'b0;
      claim_r     <= 1'b0;
      out_valid_r <= 1'b0;
      pend_r      <= '0;
      insvc_r     <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en_r[c]     <= '0;
        thr_r[c]    <= '0;
        best_p_r[c] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r <= 1'b0;
      // Scan evaluation in the cycle after the memory read.
      if (rd_v_r) begin
        for (int c = 0; c < NUM_CONTEXTS; c++) begin
          if (pend_r[rd_id_r] && en_r[c][rd_id_r] && (mem_rdata > thr_r[c]) &&
              (mem_rdata > best_p_r[c])) begin
            best_p_r[c] <= mem_rdata;
          end
        end
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            claim_r   <= 1'b0;
            scan_id_r <= SC_W'(1);
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
              best_p_r[c] <= '0;
            end
            state_r <= S_SCAN;
            case (in_data.mode)
              MODE_READ: begin
                if (is_prio) begin
                  state_r <= S_PRD;
                end else if (is_ctx && cx_ok && cx_reg == REG_CLAIM) begin
                  claim_r <= 1'b1;
                end
              end
              MODE_WRITE: begin
                if (is_en && en_ok) begin
                  en_r[en_ci][en_wi*32 +: 32] <= in_data.write_data & wmask;
                end
                if (is_ctx && cx_ok && cx_reg == REG_THRESH) begin
                  thr_r[cx_ci] <= in_data.write_data[PRIO_BITS-1:0];
                end
                if (is_ctx && cx_ok && cx_reg == REG_CLAIM && cmp_ok) begin
                  insvc_r[cmp_i] <= 1'b0;
                end
              end
              MODE_REQ: begin
                if (src_ok && !insvc_r[src_i]) begin
                  pend_r[src_i] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PRD: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          rd_v_r    <= 1'b1;
          scan_id_r <= scan_id_r + 1'b1;
          if (scan_id_r == SC_W'(NUM_SOURCES - 1)) begin
            state_r <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state_r <= S_END;
        end
        S_END: begin
          if (claim_r) begin
            // First pass picked the winner; commit it and rescan for the lines.
            claim_r <= 1'b0;
            if (best_p_r[claim_ctx_r] != '0) begin
              pend_r[claim_id]  <= 1'b0;
              insvc_r[claim_id] <= 1'b1;
            end
            scan_id_r <= SC_W'(1);
            for (int c = 0; c < NUM_CONTEXTS; c++) begin
              best_p_r[c] <= '0;
            end
            state_r <= S_SCAN;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        if (pend_r[rd_id_r] && en_r[c][rd_id_r] && (mem_rdata > thr_r[c]) &&
            (mem_rdata > best_p_r[c])) begin
          best_id_r[c] <= rd_id_r;
        end
      end
    end
    if (state_r == S_SCAN) begin
      rd_id_r <= ID_W'(scan_id_r);
    end
    if (acc) begin
      // Only bus reads return data; writes, source requests and unknown modes return zero.
      rd_r        <= (in_data.mode == MODE_READ) ? rd_val : 32'd0;
      prio_ok_r   <= prio_ok;
      claim_ctx_r <= cx_ci;
    end
    if (state_r == S_PRD) begin
      rd_r <= prio_ok_r ? 32'(mem_rdata) : 32'd0;
    end
    if (state_r == S_END && claim_r) begin
      rd_r <= (best_p_r[claim_ctx_r] != '0) ? 32'(claim_id) : 32'd0;
    end
    if (state_r == S_OUT && out_free) begin
      out_r.read_data <= rd_r;
      out_r.irq_lines <= lines;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// File: tb/platform_interrupt_controller_unit_tb.sv
// Self-checking testbench of the platform interrupt controller: directed and random bus and request traffic.
`timescale 1ns / 1ps
module platform_interrupt_controller_unit_tb;
  import pic_pkg::*;

  localparam int NSRC = 96;
  localparam int NCTX = 2;
  localparam int NWORDS = 3;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RANDOM_ITEMS = 1100;

  // Mirror of the controller's state, and the expected responses in order.
  class plic_scoreboard;
    logic [2:0] prio [NSRC];
    bit pending [NSRC];
    bit in_service [NSRC];
    logic [31:0] enables [NCTX][NWORDS];
    logic [2:0] thresh [NCTX];
    out_item_t expected_q [$];
    int mismatches;

    function void clear_state();
      for (int i = 0; i < NSRC; i++) begin
        prio[i] = '0;
        pending[i] = 0;
        in_service[i] = 0;
      end
      for (int c = 0; c < NCTX; c++) begin
        thresh[c] = '0;
        for (int w = 0; w < NWORDS; w++) enables[c][w] = '0;
      end
      expected_q.delete();
      mismatches = 0;
    endfunction

    function bit is_enabled(int ctx, int id);
      return enables[ctx][id / 32][id % 32];
    endfunction

    // Highest priority eligible source for a context, lowest id on ties.
    function int best_source(int ctx);
      int best;
      int bestp;
      best = 0;
      bestp = 0;
      for (int id = 1; id < NSRC; id++) begin
        if (pending[id] && is_enabled(ctx, id) && prio[id] > thresh[ctx] &&
            prio[id] > bestp) begin
          best = id;
          bestp = prio[id];
        end
      end
      return best;
    endfunction

    function logic [31:0] bus_read(logic [25:0] addr);
      logic [31:0] v;
      int id;
      int w;
      int ctx;
      int offs;
      v = '0;
      if (addr < PEND_BASE) begin
        id = addr >> 2;
        if (id > 0 && id < NSRC) v = prio[id];
      end else if (addr < ENABLE_BASE) begin
        w = (addr - PEND_BASE) >> 2;
        if (w < NWORDS) begin
          for (int b = 0; b < 32; b++) begin
            id = w * 32 + b;
            if (id > 0 && id < NSRC && pending[id]) v[b] = 1'b1;
          end
        end
      end else if (addr < CTX_BASE) begin
        offs = addr - ENABLE_BASE;
        ctx = offs / 'h80;
        w = (offs % 'h80) >> 2;
        if (ctx < NCTX && w < NWORDS) v = enables[ctx][w];
      end else begin
        offs = addr - CTX_BASE;
        ctx = offs / 'h1000;
        if (ctx < NCTX) begin
          if (offs % 'h1000 == REG_THRESH) begin
            v = thresh[ctx];
          end else if (offs % 'h1000 == REG_CLAIM) begin
            id = best_source(ctx);
            if (id != 0) begin
              pending[id] = 0;
              in_service[id] = 1;
            end
            v = id;
          end
        end
      end
      return v;
    endfunction

    function void bus_write(logic [25:0] addr, logic [31:0] data);
      int id;
      int w;
      int ctx;
      int offs;
      if (addr < PEND_BASE) begin
        id = addr >> 2;
        if (id > 0 && id < NSRC) prio[id] = data[2:0];
      end else if (addr < ENABLE_BASE) begin
        // The pending words cannot be written.
      end else if (addr < CTX_BASE) begin
        offs = addr - ENABLE_BASE;
        ctx = offs / 'h80;
        w = (offs % 'h80) >> 2;
        if (ctx < NCTX && w < NWORDS) enables[ctx][w] = (w == 0) ? (data & ~32'd1) : data;
      end else begin
        offs = addr - CTX_BASE;
        ctx = offs / 'h1000;
        if (ctx < NCTX) begin
          if (offs % 'h1000 == REG_THRESH) begin
            thresh[ctx] = data[2:0];
          end else if (offs % 'h1000 == REG_CLAIM) begin
            if (data > 0 && data < NSRC && is_enabled(ctx, data)) in_service[data] = 0;
          end
        end
      end
    endfunction

    // Applies one accepted request to the mirror and queues its response.
    function void note_request(in_item_t req);
      out_item_t resp;
      logic [25:0] addr;
      addr = {req.address[25:2], 2'b00};
      resp = '0;
      if (req.mode == MODE_READ) begin
        resp.read_data = bus_read(addr);
      end else if (req.mode == MODE_WRITE) begin
        bus_write(addr, req.write_data);
      end else if (req.mode == MODE_REQ) begin
        if (req.source_id > 0 && req.source_id < NSRC && !in_service[req.source_id])
          pending[req.source_id] = 1;
      end
      for (int c = 0; c < NCTX; c++) resp.irq_lines[c] = (best_source(c) != 0);
      expected_q.push_back(resp);
    endfunction

    function void check_response(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      exp_item = expected_q.pop_front();
      if (got.read_data !== exp_item.read_data || got.irq_lines !== exp_item.irq_lines) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: read_data exp %h got %h, irq_lines exp %b got %b",
                   exp_item.read_data, got.read_data, exp_item.irq_lines, got.irq_lines);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  plic_scoreboard sb;
  bit quiet_phase;
  int idle_cycles;

  platform_interrupt_controller_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Both handshakes are observed at the clock edge, against the values driven before it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_response(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls in short random bursts, except in the quiet tail of the run.
  initial begin
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // The watchdog ends the run when nothing moves for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Drives one request and holds it until it is accepted.
  task automatic send_request(logic [1:0] mode, logic [25:0] addr, logic [31:0] data,
                              logic [6:0] src);
    in_item_t req;
    req.mode = mode;
    req.address = addr;
    req.write_data = data;
    req.source_id = src;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic bus_write(logic [25:0] addr, logic [31:0] data);
    send_request(MODE_WRITE, addr, data, $urandom);
  endtask

  task automatic bus_read(logic [25:0] addr);
    send_request(MODE_READ, addr, $urandom, $urandom);
  endtask

  function automatic logic [25:0] claim_addr(int ctx);
    return CTX_BASE + ctx * 'h1000 + REG_CLAIM;
  endfunction

  function automatic logic [25:0] thresh_addr(int ctx);
    return CTX_BASE + ctx * 'h1000 + REG_THRESH;
  endfunction

  function automatic logic [25:0] enable_addr(int ctx, int w);
    return ENABLE_BASE + ctx * 'h80 + w * 4;
  endfunction

  // Mostly well-formed traffic: requests, claims, completes and register accesses on the
  // mapped registers, with some reads and writes of raw random addresses and odd modes mixed in.
  task automatic random_request();
    int pick;
    int ctx;
    logic [25:0] addr;
    logic [31:0] data;
    pick = $urandom_range(0, 99);
    ctx = $urandom_range(0, NCTX);
    addr = $urandom;
    data = $urandom;
    if (pick < 30) begin
      send_request(MODE_REQ, $urandom, data, $urandom_range(0, 100));
    end else if (pick < 45) begin
      bus_read(claim_addr(ctx));
    end else if (pick < 57) begin
      // Complete mostly a real source id, sometimes an arbitrary value.
      bus_write(claim_addr(ctx), ($urandom_range(0, 4) == 0) ? data : $urandom_range(0, 100));
    end else if (pick < 65) begin
      bus_write($urandom_range(0, NSRC + 2) * 4 + $urandom_range(0, 3), data);
    end else if (pick < 70) begin
      bus_write(enable_addr(ctx, $urandom_range(0, 31)), data);
    end else if (pick < 74) begin
      bus_write(thresh_addr(ctx), ($urandom_range(0, 1)) ? data : $urandom_range(0, 3));
    end else if (pick < 86) begin
      case ($urandom_range(0, 3))
        0: bus_read($urandom_range(0, NSRC + 2) * 4);
        1: bus_read(PEND_BASE + $urandom_range(0, 4) * 4);
        2: bus_read(enable_addr(ctx, $urandom_range(0, 4)));
        default: bus_read(thresh_addr(ctx) + $urandom_range(0, 3) * 4);
      endcase
    end else if (pick < 93) begin
      bus_read(addr);
    end else if (pick < 97) begin
      bus_write(addr, data);
    end else begin
      send_request(2'd3, addr, data, $urandom);
    end
  endtask

  task automatic wait_for_responses();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear_state();
    quiet_phase = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: priorities at the extremes, enables in the first and last words, gateway behavior.
    bus_write(26'h4, 32'hFFFF_FFFF);
    bus_write((NSRC - 1) * 4, 32'h5);
    bus_write(26'h0, 32'h7);
    bus_write(26'h8 + 2'b11, 32'h7);
    bus_write(enable_addr(0, 0), 32'hFFFF_FFFF);
    bus_write(enable_addr(0, 2), 32'hFFFF_FFFF);
    bus_write(enable_addr(1, 0), 32'h0000_0006);
    bus_write(thresh_addr(1), 32'hFFFF_FFFE);
    send_request(MODE_REQ, '0, '0, 7'd1);
    send_request(MODE_REQ, '0, '0, 7'd2);
    send_request(MODE_REQ, '0, '0, 7'd0);
    send_request(MODE_REQ, '0, '0, 7'd127);
    send_request(MODE_REQ, '0, '0, NSRC - 1);
    bus_read(PEND_BASE);
    bus_read(claim_addr(0));
    send_request(MODE_REQ, '0, '0, 7'd1);
    bus_read(claim_addr(1));
    bus_read(claim_addr(0));
    bus_write(claim_addr(0), 32'd1);
    bus_write(claim_addr(1), 32'd95);
    bus_read(thresh_addr(1));
    bus_read(26'h3FF_FFFF);
    send_request(2'd3, 26'h3FF_FFFF, 32'hFFFF_FFFF, 7'h7F);
    bus_write(thresh_addr(1), 32'h0);

    // The sender holds off until every response is back, then continues at random.
    wait_for_responses();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_for_responses();
      if (n == RANDOM_ITEMS - 100) quiet_phase = 1;
      random_request();
    end
    wait_for_responses();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: platform_interrupt_controller_unit.f
src/pic_pkg.sv
src/pic_prio_mem.sv
src/platform_interrupt_controller_unit.sv
tb/platform_interrupt_controller_unit_tb.sv
